[rtl/nidv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nidv_pkg;

   localparam int ID_LENGTH = 11;
   localparam int COUNT_SAT = 12;
   localparam int COUNT_W   = 4;

   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_NINE = 8'd57;

   localparam logic [11:0] CENTURY_1800 = 12'd1800;
   localparam logic [11:0] CENTURY_1900 = 12'd1900;
   localparam logic [11:0] CENTURY_2000 = 12'd2000;
   localparam logic [11:0] CENTURY_2100 = 12'd2100;
   localparam logic [11:0] CENTURY_2200 = 12'd2200;

   localparam logic [1:0] SEX_FEMALE  = 2'd0;
   localparam logic [1:0] SEX_MALE    = 2'd1;
   localparam logic [1:0] SEX_UNKNOWN = 2'd2;

   // checksum weights for digits one to ten
   localparam logic [3:0] WEIGHT_TAB [ID_LENGTH-1] = '{
      4'd9, 4'd7, 4'd3, 4'd1, 4'd9, 4'd7, 4'd3, 4'd1, 4'd9, 4'd7
   };

   typedef logic [ID_LENGTH-1:0][3:0] digits_type;

   typedef struct packed {
      logic len_ok;
      logic bad;
   } eval_type;

   typedef struct packed {
      logic        number_ok;
      logic [11:0] birth_year;
      logic [6:0]  birth_month;
      logic [6:0]  birth_day;
      logic [1:0]  sex_code;
   } result_type;

endpackage

`default_nettype wire

[rtl/nidv_check.sv]
`timescale 1ns / 1ps
`default_nettype none

module nidv_check (
   input  wire nidv_pkg::digits_type digits,
   input  wire nidv_pkg::eval_type   eval,
   output nidv_pkg::result_type      result
);
   import nidv_pkg::*;

   logic [8:0]  sum;
   logic [16:0] prod;
   logic [5:0]  quot;
   logic [8:0]  rem;
   logic        sum_ok;
   logic [6:0]  yy;
   logic [6:0]  raw;
   logic [6:0]  day;
   logic [6:0]  month;
   logic [11:0] century;
   logic [11:0] year;
   logic        leap;
   logic [6:0]  dim;
   logic        month_ok;
   logic        day_ok;
   logic        ok;

   always_comb begin
      sum = '0;
      for (int i = 0; i < ID_LENGTH - 1; i++) begin
         sum = sum + 9'(WEIGHT_TAB[i]) * 9'(digits[i]);
      end
      // sum mod 10 by reciprocal, exact for sums below 512
      prod   = 17'(sum) * 17'd205;
      quot   = prod[16:11];
      rem    = sum - 9'(quot) * 9'd10;
      sum_ok = (rem[3:0] == digits[ID_LENGTH-1]);

      yy  = 7'(digits[0]) * 7'd10 + 7'(digits[1]);
      raw = 7'(digits[2]) * 7'd10 + 7'(digits[3]);
      day = 7'(digits[4]) * 7'd10 + 7'(digits[5]);

      century = '0;
      month   = raw;
      if (raw inside {[7'd81:7'd92]}) begin
         century = CENTURY_1800;
         month   = raw - 7'd80;
      end else if (raw inside {[7'd1:7'd12]}) begin
         century = CENTURY_1900;
      end else if (raw inside {[7'd21:7'd32]}) begin
         century = CENTURY_2000;
         month   = raw - 7'd20;
      end else if (raw inside {[7'd41:7'd52]}) begin
         century = CENTURY_2100;
         month   = raw - 7'd40;
      end else if (raw inside {[7'd61:7'd72]}) begin
         century = CENTURY_2200;
         month   = raw - 7'd60;
      end
      year = century + 12'(yy);

      // century years are leap only for the 2000s
      leap = (yy == 7'd0) ? (century == CENTURY_2000) : (yy[1:0] == 2'b00);

      case (month)
         7'd2:    dim = leap ? 7'd29 : 7'd28;
         7'd4,
         7'd6,
         7'd9,
         7'd11:   dim = 7'd30;
         default: dim = 7'd31;
      endcase

      month_ok = (month >= 7'd1) && (month <= 7'd12);
      day_ok   = month_ok && (day >= 7'd1) && (day <= dim);
      ok       = eval.len_ok && !eval.bad && sum_ok && day_ok;

      if (eval.len_ok) begin
         result.number_ok   = ok;
         result.birth_year  = year;
         result.birth_month = month;
         result.birth_day   = day;
         if (ok) begin
            result.sex_code = digits[ID_LENGTH-2][0] ? SEX_MALE : SEX_FEMALE;
         end else begin
            result.sex_code = SEX_UNKNOWN;
         end
      end else begin
         result.number_ok   = 1'b0;
         result.birth_year  = '0;
         result.birth_month = '0;
         result.birth_day   = '0;
         result.sex_code    = SEX_UNKNOWN;
      end
   end

endmodule

`default_nettype wire

[rtl/national_id_number_validator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Checks an 11-digit Polish personal ID sent as ASCII characters, one request
// per cycle, with req_last on the final character. Characters are counted
// (saturating at 12) and their digits kept in a register file; a request with
// req_last raises one response via eval_ff and rsp_ff, carrying validity
// (length, digits only, 9-7-3-1 checksum, month and day with leap years), the
// decoded birth date and the sex. A wrong length gives zero date fields and sex
// unknown (2). Throughput is one character per cycle; the input stalls only
// while a finished check waits behind an unconsumed response register.
module national_id_number_validator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_number_ok,
   output logic [11:0]      rsp_birth_year,
   output logic [6:0]       rsp_birth_month,
   output logic [6:0]       rsp_birth_day,
   output logic [1:0]       rsp_sex_code
);
   import nidv_pkg::*;

   digits_type        digit_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic              bad_ff, bad_in;
   logic              eval_valid_ff, eval_valid_in;
   eval_type          eval_ff, eval_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   result_type        check_res;

   logic              req_fire;
   logic              rsp_free;
   logic              is_digit;
   logic [3:0]        digit_in;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !eval_valid_ff || rsp_free;
   assign req_fire  = req_valid && req_ready;
   assign is_digit  = req_char_code inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit_in  = is_digit ? 4'(req_char_code - CHAR_ZERO) : 4'd0;

   always_comb begin
      count_in      = count_ff;
      bad_in        = bad_ff;
      eval_in       = eval_ff;
      eval_valid_in = eval_valid_ff && !rsp_free;
      rsp_valid_in  = eval_valid_ff || (rsp_valid_ff && !rsp_ready);
      if (req_fire) begin
         if (req_last) begin
            count_in      = '0;
            bad_in        = 1'b0;
            eval_valid_in = 1'b1;
            eval_in.len_ok = (count_ff == COUNT_W'(ID_LENGTH - 1));
            eval_in.bad    = bad_ff || !is_digit;
         end else begin
            bad_in = bad_ff || !is_digit;
            if (count_ff < COUNT_W'(COUNT_SAT)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         bad_ff        <= 1'b0;
         eval_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         bad_ff        <= bad_in;
         eval_valid_ff <= eval_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      eval_ff <= eval_in;
      if (req_fire && count_ff < COUNT_W'(ID_LENGTH)) begin
         digit_ff[count_ff] <= digit_in;
      end
      if (eval_valid_ff && rsp_free) begin
         rsp_ff <= check_res;
      end
   end

   nidv_check u_check (
      .digits (digit_ff),
      .eval   (eval_ff),
      .result (check_res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_number_ok   = rsp_ff.number_ok;
   assign rsp_birth_year  = rsp_ff.birth_year;
   assign rsp_birth_month = rsp_ff.birth_month;
   assign rsp_birth_day   = rsp_ff.birth_day;
   assign rsp_sex_code    = rsp_ff.sex_code;

endmodule

`default_nettype wire
